### src/srrip_sb_pkg.sv
// Shared types and constants of the SRRIP replacement block with stream bypass.
// Used by the controller, the datapath and the top level; depends on nothing.
package srrip_sb_pkg;

  localparam int unsigned NUM_SETS    = 2048;
  localparam int unsigned NUM_WAYS    = 16;
  localparam int unsigned HISTORY_LEN = 4;
  localparam int unsigned ADDR_BITS   = 48;

  localparam int unsigned SET_W = $clog2(NUM_SETS);
  localparam int unsigned WAY_W = $clog2(NUM_WAYS);
  localparam int unsigned PTR_W = $clog2(HISTORY_LEN);
  localparam int unsigned CNT_W = $clog2(HISTORY_LEN + 1);
  localparam int unsigned THR_W = 3;
  localparam int unsigned OTH_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTCOME_THR = 2'd1;

  localparam logic [THR_W-1:0] STREAM_THR_RESET  = 3'd3;
  localparam logic [OTH_W-1:0] OUTCOME_THR_RESET = 2'd1;

  localparam logic [1:0] RR_DISTANT    = 2'd3;
  localparam logic [1:0] RR_NEAR       = 2'd0;
  localparam logic [1:0] OUTCOME_TOP   = 2'd3;
  localparam logic [1:0] OUTCOME_ZERO  = 2'd0;
  localparam logic [1:0] OUTCOME_RESET = 2'd1;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_WRITE
  } state_e;

  typedef logic [NUM_WAYS-1:0][1:0]    way_vec_t;
  typedef logic [HISTORY_LEN-1:0][1:0] ring_t;

  typedef struct packed {
    way_vec_t              rr;
    way_vec_t              outc;
    logic [ADDR_BITS-1:0]  prev;
    ring_t                 ring;
    logic [PTR_W-1:0]      ptr;
    logic                  flag;
  } row_t;

  localparam row_t ROW_RESET = '{
    rr:   {NUM_WAYS{RR_DISTANT}},
    outc: {NUM_WAYS{OUTCOME_RESET}},
    prev: '0,
    ring: {HISTORY_LEN{SIGN_ZERO}},
    ptr:  '0,
    flag: 1'b0
  };

  typedef struct packed {
    logic clear;
    logic accept;
    logic eval;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

### src/srrip_stream_bypass_replacement.sv
// Top level of the SRRIP replacement block with per-set stream bypass.
// Instantiates srrip_sb_ctrl and srrip_sb_dpath; uses srrip_sb_pkg.
//
//   Channel   Handshake                  Payload
//   cfg       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in        in_valid_i  / in_ready_o   op_i, set_index_i, way_index_i, phys_addr_i, was_hit_i
//   out       out_valid_o / out_ready_i  victim_way_o, set_streaming_o
//
// Each item passes through accept with the set row read, evaluate, and
// write-back of the row, all on the single port of the per-set state memory.
// After reset a clearing pass writes every set row while no item is taken;
// configuration transfers are taken at any time.
// The result register holds a finished result while the next item is taken;
// the write-back step waits only while that register is still full.
module srrip_stream_bypass_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [10:0] set_index_i,
  input  logic [3:0]  way_index_i,
  input  logic [47:0] phys_addr_i,
  input  logic        was_hit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  victim_way_o,
  output logic        set_streaming_o
);

  srrip_sb_pkg::cmd_t    cmd;
  srrip_sb_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  srrip_sb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srrip_sb_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .set_index_i     (set_index_i),
    .way_index_i     (way_index_i),
    .phys_addr_i     (phys_addr_i),
    .was_hit_i       (was_hit_i),
    .victim_way_o    (victim_way_o),
    .set_streaming_o (set_streaming_o)
  );

  a_accept_then_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> cmd.eval)
    else $error("Evaluation step did not follow an accepted transfer.");

  a_one_item_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Input ready stayed high after a transfer.");

  a_commit_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("Output valid missing after write-back.");

  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> (!in_ready_o && !cmd.commit))
    else $error("Item activity during the clearing pass.");

endmodule

### src/srrip_sb_ctrl.sv
// Sequencing state machine of the replacement block: clearing pass, accept,
// evaluate and write-back steps, and the output valid flag. Uses srrip_sb_pkg.
module srrip_sb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  srrip_sb_pkg::status_t status_i,
  output srrip_sb_pkg::cmd_t    cmd_o
);

  srrip_sb_pkg::state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srrip_sb_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      srrip_sb_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = srrip_sb_pkg::ST_IDLE;
        end
      end
      srrip_sb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = srrip_sb_pkg::ST_EVAL;
        end
      end
      srrip_sb_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = srrip_sb_pkg::ST_WRITE;
      end
      srrip_sb_pkg::ST_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = srrip_sb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srrip_sb_pkg::ST_CLEAR;
      end
    endcase

    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/srrip_sb_dpath.sv
// Datapath of the replacement block: per-set state memory, configuration
// registers, victim search, stream detector and block update. Uses srrip_sb_pkg.
module srrip_sb_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  srrip_sb_pkg::cmd_t                    cmd_i,
  output srrip_sb_pkg::status_t                 status_o,
  input  logic                                  cfg_valid_i,
  input  logic [srrip_sb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [srrip_sb_pkg::THR_W-1:0]        cfg_data_i,
  input  logic                                  op_i,
  input  logic [10:0]                           set_index_i,
  input  logic [3:0]                            way_index_i,
  input  logic [47:0]                           phys_addr_i,
  input  logic                                  was_hit_i,
  output logic [3:0]                            victim_way_o,
  output logic                                  set_streaming_o
);

  localparam int unsigned SET_W = srrip_sb_pkg::SET_W;
  localparam int unsigned WAY_W = srrip_sb_pkg::WAY_W;
  localparam int unsigned PTR_W = srrip_sb_pkg::PTR_W;
  localparam int unsigned CNT_W = srrip_sb_pkg::CNT_W;
  localparam int unsigned NWAYS = srrip_sb_pkg::NUM_WAYS;
  localparam int unsigned HLEN  = srrip_sb_pkg::HISTORY_LEN;

  srrip_sb_pkg::row_t mem [srrip_sb_pkg::NUM_SETS];

  logic [srrip_sb_pkg::THR_W-1:0] stream_thr_q;
  logic [srrip_sb_pkg::OTH_W-1:0] outcome_thr_q;
  logic [SET_W-1:0]               clr_cnt_q;

  logic                                op_q;
  logic [SET_W-1:0]                    set_q;
  logic [WAY_W-1:0]                    way_q;
  logic [srrip_sb_pkg::ADDR_BITS-1:0]  addr_q;
  logic                                hit_q;

  srrip_sb_pkg::row_t rd_row_q;

  logic [WAY_W-1:0]       victim_q, victim_d;
  srrip_sb_pkg::way_vec_t rr_eval_q, rr_eval_d;
  srrip_sb_pkg::ring_t    ring_q, ring_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic                   flag_q, flag_d;

  logic                   wr_en;
  logic [SET_W-1:0]       wr_addr;
  srrip_sb_pkg::row_t     wr_row;
  logic [3:0]             victim_d_out;
  logic                   streaming_d_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_thr_q  <= srrip_sb_pkg::STREAM_THR_RESET;
      outcome_thr_q <= srrip_sb_pkg::OUTCOME_THR_RESET;
      clr_cnt_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == srrip_sb_pkg::CFG_STREAM_THR) begin
        stream_thr_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == srrip_sb_pkg::CFG_OUTCOME_THR) begin
        outcome_thr_q <= cfg_data_i[srrip_sb_pkg::OTH_W-1:0];
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign status_o.clear_last = (clr_cnt_q == SET_W'(srrip_sb_pkg::NUM_SETS - 1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd_i.accept) begin
      rd_row_q <= mem[set_index_i[SET_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      set_q  <= set_index_i[SET_W-1:0];
      way_q  <= way_index_i[WAY_W-1:0];
      addr_q <= phys_addr_i[srrip_sb_pkg::ADDR_BITS-1:0];
      hit_q  <= was_hit_i;
    end
    if (cmd_i.eval) begin
      victim_q  <= victim_d;
      rr_eval_q <= rr_eval_d;
      ring_q    <= ring_d;
      ptr_q     <= ptr_d;
      flag_q    <= flag_d;
    end
    if (cmd_i.commit) begin
      victim_way_o    <= victim_d_out;
      set_streaming_o <= streaming_d_out;
    end
  end

  // Victim search with one aging pass, and the stream detector.
  always_comb begin
    logic             found1;
    logic             found2;
    logic [WAY_W-1:0] way1;
    logic [WAY_W-1:0] way2;
    logic [1:0]       code;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] neg;
    logic [CNT_W-1:0] nz;

    found1 = 1'b0;
    found2 = 1'b0;
    way1   = '0;
    way2   = '0;
    for (int w = NWAYS - 1; w >= 0; w--) begin
      if (rd_row_q.rr[w] == srrip_sb_pkg::RR_DISTANT) begin
        found1 = 1'b1;
        way1   = WAY_W'(w);
      end
      if (rd_row_q.rr[w] == srrip_sb_pkg::RR_DISTANT - 2'd1) begin
        found2 = 1'b1;
        way2   = WAY_W'(w);
      end
    end
    for (int w = 0; w < NWAYS; w++) begin
      if (found1 || rd_row_q.rr[w] == srrip_sb_pkg::RR_DISTANT) begin
        rr_eval_d[w] = rd_row_q.rr[w];
      end else begin
        rr_eval_d[w] = rd_row_q.rr[w] + 2'd1;
      end
    end
    if (found1) begin
      victim_d = way1;
    end else if (found2) begin
      victim_d = way2;
    end else begin
      victim_d = '0;
    end

    if (addr_q > rd_row_q.prev) begin
      code = srrip_sb_pkg::SIGN_POS;
    end else if (addr_q < rd_row_q.prev) begin
      code = srrip_sb_pkg::SIGN_NEG;
    end else begin
      code = srrip_sb_pkg::SIGN_ZERO;
    end
    ring_d = rd_row_q.ring;
    ptr_d  = rd_row_q.ptr;
    if (rd_row_q.prev != '0) begin
      ring_d[rd_row_q.ptr] = code;
      if (rd_row_q.ptr == PTR_W'(HLEN - 1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = rd_row_q.ptr + 1'b1;
      end
    end
    pos = '0;
    neg = '0;
    nz  = '0;
    for (int i = 0; i < HLEN; i++) begin
      if (ring_d[i] == srrip_sb_pkg::SIGN_POS) begin
        pos = pos + 1'b1;
      end
      if (ring_d[i] == srrip_sb_pkg::SIGN_NEG) begin
        neg = neg + 1'b1;
      end
      if (ring_d[i] != srrip_sb_pkg::SIGN_ZERO) begin
        nz = nz + 1'b1;
      end
    end
    flag_d = (nz >= stream_thr_q) && ((pos >= stream_thr_q) || (neg >= stream_thr_q));
  end

  // Write-back row and result of the item, or the reset row during the clearing pass.
  always_comb begin
    logic [1:0] outc;

    outc   = rd_row_q.outc[way_q];
    wr_row = rd_row_q;
    if (op_q == srrip_sb_pkg::OP_VICTIM) begin
      wr_row.rr       = rr_eval_q;
      victim_d_out    = 4'(victim_q);
      streaming_d_out = rd_row_q.flag;
    end else begin
      wr_row.prev = addr_q;
      wr_row.ring = ring_q;
      wr_row.ptr  = ptr_q;
      wr_row.flag = flag_q;
      if (flag_q) begin
        wr_row.rr[way_q]   = srrip_sb_pkg::RR_DISTANT;
        wr_row.outc[way_q] = srrip_sb_pkg::OUTCOME_ZERO;
      end else if (hit_q) begin
        wr_row.rr[way_q] = srrip_sb_pkg::RR_NEAR;
        if (outc != srrip_sb_pkg::OUTCOME_TOP) begin
          wr_row.outc[way_q] = outc + 2'd1;
        end
      end else begin
        if (outc > outcome_thr_q) begin
          wr_row.rr[way_q] = srrip_sb_pkg::RR_NEAR;
        end else begin
          wr_row.rr[way_q] = srrip_sb_pkg::RR_DISTANT;
        end
        if (outc != srrip_sb_pkg::OUTCOME_ZERO) begin
          wr_row.outc[way_q] = outc - 2'd1;
        end
      end
      victim_d_out    = '0;
      streaming_d_out = flag_q;
    end

    if (cmd_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_row  = srrip_sb_pkg::ROW_RESET;
    end else begin
      wr_en   = cmd_i.commit;
      wr_addr = set_q;
    end
  end

endmodule
